// ===== design/assert_macros.svh =====
// Assertion macros shared by the cache lookup design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SACL_CHECK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SACL_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sacl_pkg.sv =====
// Shared constants and types for the set-associative cache lookup.
`default_nettype none

package sacl_pkg;

  // Fixed field widths.
  localparam int ADDR_W       = 64;
  localparam int COUNT_W      = 32;
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 3;
  localparam int BLOCK_BITS_W = 6;
  // The set index source is at most 2**SET_BITS_W - 1 bits wide.
  localparam int SET_SRC_W    = 7;

  // Default geometry.
  localparam int NUM_SETS_DEF = 32;
  localparam int NUM_WAYS_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST    = 3'd0;
  localparam logic [WAYS_W-1:0]       WAYS_RST        = 3'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST  = 6'd0;

  // Access outcome codes.
  typedef enum logic [1:0] {
    OUTCOME_HIT   = 2'd0,
    OUTCOME_FILL  = 2'd1,
    OUTCOME_EVICT = 2'd2
  } outcome_t;

  // Lookup verdict handed from the set logic to the control.
  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } lookup_res_t;

endpackage

`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup.sv =====
// Set-associative cache lookup with LRU replacement: top level.
//
// Usage: each address word on the input channel (in_valid/in_ready) is split
// into block offset, set index and tag by the configured bit counts. The set
// row (valid bits, tags and LRU ranks of all ways) is read from a synchronous
// RAM, checked, updated and written back. One result word per
// address leaves on the output channel (out_valid/out_ready): the outcome
// (hit, fill of an empty way, eviction) and the running hit, miss and
// eviction counts including this access.
// Throughput: one address per cycle while the output channel does not stall;
// the set RAM is read at acceptance and written back when the lookup
// completes, and a back-to-back access to the same set takes the freshly
// written row from a forwarding register.
// Reset: configuration returns to its defaults, counters clear, and a
// clearing pass writes every set row to zero, one row a cycle; no address is
// taken during that pass. Stall: while a result waits, one more address is
// accepted and held at the lookup stage until the output register frees up.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data only while
// idle, by the user; the block itself does not enforce this.
`default_nettype none

module set_assoc_cache_lru_lookup #(
  parameter int NumSets = sacl_pkg::NUM_SETS_DEF,
  parameter int NumWays = sacl_pkg::NUM_WAYS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [sacl_pkg::ADDR_W-1:0]         address,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [1:0]                          outcome,
  output logic      [sacl_pkg::COUNT_W-1:0]        hit_count,
  output logic      [sacl_pkg::COUNT_W-1:0]        miss_count,
  output logic      [sacl_pkg::COUNT_W-1:0]        eviction_count
);

`include "assert_macros.svh"

  localparam int SetW   = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int RankW  = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int SrcN   = 2 ** sacl_pkg::SET_SRC_W;
  localparam int AddrW  = sacl_pkg::ADDR_W;
  localparam int CountW = sacl_pkg::COUNT_W;

  typedef struct packed {
    logic [NumWays-1:0]            valid;
    logic [NumWays-1:0][AddrW-1:0] tag;
    logic [NumWays-1:0][RankW-1:0] rank;
  } row_t;

  localparam int RowW = $bits(row_t);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits;
  logic [sacl_pkg::WAYS_W-1:0]       ways_in_use;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits;

  logic [SetW-1:0]                 clr_idx;
  logic [SetW-1:0]                 set_lut [SrcN];
  logic [AddrW-1:0]                above;
  logic [sacl_pkg::SET_SRC_W-1:0]  set_mask;
  logic [sacl_pkg::SET_SRC_W-1:0]  set_src;
  logic [SetW-1:0]                 set_in;
  logic [sacl_pkg::SET_SRC_W-1:0]  tag_shift;
  logic [AddrW-1:0]                tag_in;

  logic [SetW-1:0]  cur_set;
  logic [AddrW-1:0] cur_tag;
  logic             fwd_hit;
  row_t             fwd_row;
  logic [RowW-1:0]  rd_data;
  row_t             cur_row;
  row_t             new_row;

  logic             in_acc;
  logic             out_free;
  logic             look_done;
  logic             clearing;
  logic             wr_en;
  logic [SetW-1:0]  wr_addr;
  row_t             wr_row;

  sacl_pkg::lookup_res_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::SET_BITS_RST;
      ways_in_use <= sacl_pkg::WAYS_RST;
      block_bits  <= sacl_pkg::BLOCK_BITS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sacl_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data[sacl_pkg::WAYS_W-1:0];
        sacl_pkg::CFG_BLOCK_BITS:  block_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Set index folding table: extracted index modulo the set count.
  for (genvar i = 0; i < SrcN; i++) begin : g_set_lut
    assign set_lut[i] = SetW'(i % NumSets);
  end

  // Address split.
  assign above     = address >> block_bits;
  assign set_mask  = ~({sacl_pkg::SET_SRC_W{1'b1}} << set_bits);
  assign set_src   = above[sacl_pkg::SET_SRC_W-1:0] & set_mask;
  assign set_in    = set_lut[set_src];
  assign tag_shift = sacl_pkg::SET_SRC_W'(block_bits) + sacl_pkg::SET_SRC_W'(set_bits);
  assign tag_in    = tag_shift[sacl_pkg::SET_SRC_W-1] ? '0 : (address >> tag_shift[5:0]);

  // Handshake control.
  assign clearing  = (state == ST_CLEAR);
  assign out_free  = !out_valid || out_ready;
  assign look_done = (state == ST_LOOK) && out_free;
  assign in_ready  = (state == ST_IDLE) || look_done;
  assign in_acc    = in_valid && in_ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == SetW'(NumSets - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_LOOK;
      ST_LOOK:  if (look_done) state_next = in_acc ? ST_LOOK : ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + SetW'(1);
      end
    end
  end

  // Lookup stage registers and same-set forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_acc) begin
      fwd_hit <= look_done && (set_in == cur_set);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_set <= set_in;
      cur_tag <= tag_in;
      fwd_row <= new_row;
    end
  end

  // Set row storage.
  sacl_ram #(
    .Width (RowW),
    .Depth (NumSets)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (in_acc),
    .rd_addr (set_in),
    .rd_data (rd_data)
  );

  assign cur_row = fwd_hit ? fwd_row : row_t'(rd_data);

  sacl_lookup #(
    .NumWays (NumWays)
  ) u_lookup (
    .row_valid   (cur_row.valid),
    .row_tag     (cur_row.tag),
    .row_rank    (cur_row.rank),
    .tag         (cur_tag),
    .ways_in_use (ways_in_use),
    .new_valid   (new_row.valid),
    .new_tag     (new_row.tag),
    .new_rank    (new_row.rank),
    .res         (res)
  );

  // Write back the updated row, or zeros during the clearing pass.
  assign wr_en   = clearing || look_done;
  assign wr_addr = clearing ? clr_idx : cur_set;
  assign wr_row  = clearing ? '0 : new_row;

  // Output register and running counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (look_done) begin
      out_valid      <= 1'b1;
      hit_count      <= hit_count + CountW'(res.hit);
      miss_count     <= miss_count + CountW'(res.fill || res.evict);
      eviction_count <= eviction_count + CountW'(res.evict);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      if (res.hit) begin
        outcome <= sacl_pkg::OUTCOME_HIT;
      end else if (res.fill) begin
        outcome <= sacl_pkg::OUTCOME_FILL;
      end else begin
        outcome <= sacl_pkg::OUTCOME_EVICT;
      end
    end
  end

  // Checks.
  `SACL_CHECK_NEXT(a_one_count_per_word, clk, rst, look_done,
    CountW'(hit_count + miss_count) == CountW'($past(hit_count + miss_count) + CountW'(1)),
    "hit plus miss count did not advance by one for a result word")
  `SACL_CHECK_NOW(a_evict_needs_miss, clk, rst, eviction_count != $past(eviction_count),
    miss_count != $past(miss_count), "eviction counted without a miss")
  `SACL_CHECK_NOW(a_quiet_while_clearing, clk, rst, state == ST_CLEAR,
    !out_valid && !in_ready, "channel active during the clearing pass")

endmodule

`default_nettype wire

// ===== design/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sacl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sacl_lookup.sv =====
// Set lookup: tag match, fill or victim choice, and LRU rank update for one set.
`default_nettype none

module sacl_lookup #(
  parameter int NumWays = sacl_pkg::NUM_WAYS_DEF,
  localparam int RankW = (NumWays > 1) ? $clog2(NumWays) : 1
) (
  input  wire logic [NumWays-1:0]                         row_valid,
  input  wire logic [NumWays-1:0][sacl_pkg::ADDR_W-1:0]   row_tag,
  input  wire logic [NumWays-1:0][RankW-1:0]              row_rank,
  input  wire logic [sacl_pkg::ADDR_W-1:0]                tag,
  input  wire logic [sacl_pkg::WAYS_W-1:0]                ways_in_use,
  output logic      [NumWays-1:0]                         new_valid,
  output logic      [NumWays-1:0][sacl_pkg::ADDR_W-1:0]   new_tag,
  output logic      [NumWays-1:0][RankW-1:0]              new_rank,
  output sacl_pkg::lookup_res_t                           res
);

  localparam int ActW = $clog2(NumWays + 8) + 1;
  localparam int OldW = RankW + 1;
  localparam logic [RankW-1:0] RankMax = RankW'(NumWays - 1);

  logic [NumWays-1:0] act;
  logic [NumWays-1:0] hit_vec;
  logic [NumWays-1:0] empty_vec;
  logic [NumWays-1:0] max_vec;
  logic [NumWays-1:0] first_hit;
  logic [NumWays-1:0] first_empty;
  logic [NumWays-1:0] first_max;
  logic [NumWays-1:0] tgt;
  logic               any_hit;
  logic               any_empty;
  logic [OldW-1:0]    older;

  // Per-way match, empty and "holds the largest rank" flags.
  always_comb begin
    for (int k = 0; k < NumWays; k++) begin
      act[k]       = (k == 0) || (ActW'(k) < ActW'(ways_in_use));
      hit_vec[k]   = act[k] && row_valid[k] && (row_tag[k] == tag);
      empty_vec[k] = act[k] && !row_valid[k];
      max_vec[k]   = act[k];
      for (int j = 0; j < NumWays; j++) begin
        if (act[j] && (row_rank[j] > row_rank[k])) begin
          max_vec[k] = 1'b0;
        end
      end
    end
  end

  // Lowest-numbered candidate of each kind.
  assign first_hit   = hit_vec & (~hit_vec + NumWays'(1));
  assign first_empty = empty_vec & (~empty_vec + NumWays'(1));
  assign first_max   = max_vec & (~max_vec + NumWays'(1));
  assign any_hit     = |hit_vec;
  assign any_empty   = |empty_vec;

  assign tgt = any_hit ? first_hit : (any_empty ? first_empty : first_max);

  // Rank below which the other ways age by one.
  always_comb begin
    older = '0;
    for (int k = 0; k < NumWays; k++) begin
      if (tgt[k]) begin
        older = {1'b0, row_rank[k]};
      end
    end
    if (!any_hit && any_empty) begin
      older = OldW'(NumWays);
    end
  end

  // Updated row: target becomes most recent, younger ways age with saturation.
  always_comb begin
    for (int j = 0; j < NumWays; j++) begin
      new_valid[j] = row_valid[j];
      new_tag[j]   = row_tag[j];
      new_rank[j]  = row_rank[j];
      if (tgt[j]) begin
        new_valid[j] = 1'b1;
        new_tag[j]   = tag;
        new_rank[j]  = '0;
      end else if (act[j] && row_valid[j] && ({1'b0, row_rank[j]} < older) &&
                   (row_rank[j] != RankMax)) begin
        new_rank[j] = row_rank[j] + RankW'(1);
      end
    end
  end

  assign res.hit   = any_hit;
  assign res.fill  = !any_hit && any_empty;
  assign res.evict = !any_hit && !any_empty;

endmodule

`default_nettype wire
